>>> design/random_elastic_collision_engine_defines.svh
// Assertion macros shared by the engine's modules.
`ifndef RANDOM_ELASTIC_COLLISION_ENGINE_DEFINES_SVH
`define RANDOM_ELASTIC_COLLISION_ENGINE_DEFINES_SVH
// Assert an implication on the next clock edge.
`define REC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
// Assert an implication on the same clock edge.
`define REC_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`endif

>>> design/rec_pkg.sv
package rec_pkg;
    localparam int unsigned PARTICLE_COUNT_DEF = 4096;
    localparam int unsigned VEL_W = 32;
    localparam int unsigned DIR_W = 16;
    localparam int unsigned IDX_W = 12;
    localparam int unsigned SCALE_SHIFT = 28;
    localparam logic signed [DIR_W-1:0] DIR_LIMIT = 16'sd16384;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_COLLIDE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    localparam logic [1:0] ST_LOADED   = 2'd0;
    localparam logic [1:0] ST_COLLIDED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;
    localparam logic [1:0] ST_READ     = 2'd3;

    typedef enum logic [1:0] {OP_LOAD, OP_READ, OP_COLLIDE, OP_REJECT} t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_A, S_RD_B, S_DIFF, S_DOT0, S_DOT1, S_SIGN,
        S_MUL0, S_MUL1, S_WR_A, S_WR_B, S_OUT
    } t_state;

    function automatic logic signed [DIR_W-1:0] clamp_dir(input logic signed [DIR_W-1:0] d);
        if (d > DIR_LIMIT) begin
            return DIR_LIMIT;
        end else if (d < -DIR_LIMIT) begin
            return -DIR_LIMIT;
        end
        return d;
    endfunction

    function automatic logic signed [VEL_W-1:0] sat32(input logic signed [VEL_W+2:0] v);
        if (v > 35'sh07FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -35'sh080000000) begin
            return 32'sh80000000;
        end
        return v[VEL_W-1:0];
    endfunction
endpackage

>>> design/random_elastic_collision_engine.sv
// Elastic collision engine. A table of PARTICLE_COUNT 3-D velocities (Q20.12)
// lives in three single-port-write, registered-read RAMs. Load transactions
// write one entry, read transactions return one, collide transactions read
// particles A and B, form k = r.(vA - vB) and, when k is positive, move the
// rounded impulse k*r from A to B with saturation, returning A's new velocity.
// A non-positive k (including one particle named twice) or request code 3
// gives status rejected with zero data. A front stage accepts and classifies
// transactions into a two-entry queue; a back sequencer executes one at a time.
// Back-end work is set by the sequencer's serial RAM reads, dot product,
// multiply and two write-backs on the shared RAM write port. Entries read
// before they are written return undefined data. No clearing pass is made
// after reset.
module random_elastic_collision_engine #(
    parameter int unsigned PARTICLE_COUNT = rec_pkg::PARTICLE_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_req_type,
    input  logic [rec_pkg::IDX_W-1:0]          i_index_a,
    input  logic [rec_pkg::IDX_W-1:0]          i_index_b,
    input  logic signed [rec_pkg::VEL_W-1:0]   i_load_x,
    input  logic signed [rec_pkg::VEL_W-1:0]   i_load_y,
    input  logic signed [rec_pkg::VEL_W-1:0]   i_load_z,
    input  logic signed [rec_pkg::DIR_W-1:0]   i_dir_x,
    input  logic signed [rec_pkg::DIR_W-1:0]   i_dir_y,
    input  logic signed [rec_pkg::DIR_W-1:0]   i_dir_z,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic signed [rec_pkg::VEL_W-1:0]   o_out_x,
    output logic signed [rec_pkg::VEL_W-1:0]   o_out_y,
    output logic signed [rec_pkg::VEL_W-1:0]   o_out_z
);
    import rec_pkg::*;

    localparam int unsigned AW = $clog2(PARTICLE_COUNT);

    // Queue between front and back.
    logic q_valid, q_ready;
    t_op  q_op;
    logic [AW-1:0] q_ia, q_ib;
    logic signed [VEL_W-1:0] q_vx, q_vy, q_vz;
    logic signed [DIR_W-1:0] q_rx, q_ry, q_rz;

    rec_front #(.PARTICLE_COUNT(PARTICLE_COUNT), .AW(AW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_index_a(i_index_a), .i_index_b(i_index_b),
        .i_load_x(i_load_x), .i_load_y(i_load_y), .i_load_z(i_load_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_op(q_op),
        .o_q_ia(q_ia), .o_q_ib(q_ib), .o_q_vx(q_vx), .o_q_vy(q_vy), .o_q_vz(q_vz),
        .o_q_rx(q_rx), .o_q_ry(q_ry), .o_q_rz(q_rz)
    );

    rec_back #(.PARTICLE_COUNT(PARTICLE_COUNT), .AW(AW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .o_q_ready(q_ready),
        .i_q_op(q_op), .i_q_ia(q_ia), .i_q_ib(q_ib),
        .i_q_vx(q_vx), .i_q_vy(q_vy), .i_q_vz(q_vz),
        .i_q_rx(q_rx), .i_q_ry(q_ry), .i_q_rz(q_rz),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z)
    );
endmodule

>>> design/rec_ram.sv
module rec_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/rec_front.sv
module rec_front #(
    parameter int unsigned PARTICLE_COUNT = rec_pkg::PARTICLE_COUNT_DEF,
    parameter int unsigned AW = $clog2(PARTICLE_COUNT)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_req_type,
    input  logic [rec_pkg::IDX_W-1:0]          i_index_a,
    input  logic [rec_pkg::IDX_W-1:0]          i_index_b,
    input  logic signed [rec_pkg::VEL_W-1:0]   i_load_x,
    input  logic signed [rec_pkg::VEL_W-1:0]   i_load_y,
    input  logic signed [rec_pkg::VEL_W-1:0]   i_load_z,
    input  logic signed [rec_pkg::DIR_W-1:0]   i_dir_x,
    input  logic signed [rec_pkg::DIR_W-1:0]   i_dir_y,
    input  logic signed [rec_pkg::DIR_W-1:0]   i_dir_z,
    output logic                               o_q_valid,
    input  logic                               i_q_ready,
    output rec_pkg::t_op                       o_q_op,
    output logic [AW-1:0]                      o_q_ia,
    output logic [AW-1:0]                      o_q_ib,
    output logic signed [rec_pkg::VEL_W-1:0]   o_q_vx,
    output logic signed [rec_pkg::VEL_W-1:0]   o_q_vy,
    output logic signed [rec_pkg::VEL_W-1:0]   o_q_vz,
    output logic signed [rec_pkg::DIR_W-1:0]   o_q_rx,
    output logic signed [rec_pkg::DIR_W-1:0]   o_q_ry,
    output logic signed [rec_pkg::DIR_W-1:0]   o_q_rz
);
    import rec_pkg::*;

    // Two-entry queue; classify and reduce indexes on entry.
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;
    t_op        r_op [2];
    logic [AW-1:0] r_ia [2], r_ib [2];
    logic signed [VEL_W-1:0] r_vx [2], r_vy [2], r_vz [2];
    logic signed [DIR_W-1:0] r_rx [2], r_ry [2], r_rz [2];
    t_op        w_op;
    logic       w_push, w_pop;
    logic [IDX_W+AW-1:0] w_ia_ext, w_ib_ext;

    assign o_ready = (r_cnt != 2'd2);
    assign w_push = i_valid && o_ready;
    assign w_pop  = o_q_valid && i_q_ready;
    assign w_ia_ext = {{AW{1'b0}}, i_index_a} % (IDX_W+AW)'(PARTICLE_COUNT);
    assign w_ib_ext = {{AW{1'b0}}, i_index_b} % (IDX_W+AW)'(PARTICLE_COUNT);

    always_comb begin
        case (i_req_type)
            REQ_LOAD:    w_op = OP_LOAD;
            REQ_READ:    w_op = OP_READ;
            REQ_COLLIDE: w_op = OP_COLLIDE;
            default:     w_op = OP_REJECT;
        endcase
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
        end
        if (w_push) begin
            r_op[r_wp] <= w_op;
            r_ia[r_wp] <= w_ia_ext[AW-1:0];
            r_ib[r_wp] <= w_ib_ext[AW-1:0];
            r_vx[r_wp] <= i_load_x;
            r_vy[r_wp] <= i_load_y;
            r_vz[r_wp] <= i_load_z;
            r_rx[r_wp] <= clamp_dir(i_dir_x);
            r_ry[r_wp] <= clamp_dir(i_dir_y);
            r_rz[r_wp] <= clamp_dir(i_dir_z);
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_op = r_op[r_rp];
    assign o_q_ia = r_ia[r_rp];
    assign o_q_ib = r_ib[r_rp];
    assign o_q_vx = r_vx[r_rp];
    assign o_q_vy = r_vy[r_rp];
    assign o_q_vz = r_vz[r_rp];
    assign o_q_rx = r_rx[r_rp];
    assign o_q_ry = r_ry[r_rp];
    assign o_q_rz = r_rz[r_rp];

`include "random_elastic_collision_engine_defines.svh"
    `REC_ASSERT_SAME(a_q_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2, "queue count overflow")
    `REC_ASSERT_NEXT(a_q_full_hold, i_clk, i_rst_n, r_cnt == 2'd2 && !w_pop, r_cnt == 2'd2, "full queue lost entry")
    `REC_ASSERT_NEXT(a_q_push, i_clk, i_rst_n, w_push && !w_pop, r_cnt == $past(r_cnt) + 2'd1, "push not counted")
endmodule

>>> design/rec_back.sv
module rec_back #(
    parameter int unsigned PARTICLE_COUNT = rec_pkg::PARTICLE_COUNT_DEF,
    parameter int unsigned AW = $clog2(PARTICLE_COUNT)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    output logic                               o_q_ready,
    input  rec_pkg::t_op                       i_q_op,
    input  logic [AW-1:0]                      i_q_ia,
    input  logic [AW-1:0]                      i_q_ib,
    input  logic signed [rec_pkg::VEL_W-1:0]   i_q_vx,
    input  logic signed [rec_pkg::VEL_W-1:0]   i_q_vy,
    input  logic signed [rec_pkg::VEL_W-1:0]   i_q_vz,
    input  logic signed [rec_pkg::DIR_W-1:0]   i_q_rx,
    input  logic signed [rec_pkg::DIR_W-1:0]   i_q_ry,
    input  logic signed [rec_pkg::DIR_W-1:0]   i_q_rz,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic signed [rec_pkg::VEL_W-1:0]   o_out_x,
    output logic signed [rec_pkg::VEL_W-1:0]   o_out_y,
    output logic signed [rec_pkg::VEL_W-1:0]   o_out_z
);
    import rec_pkg::*;

    t_state r_state, n_state;
    t_op    r_op;
    logic [AW-1:0] r_ia, r_ib;
    logic signed [DIR_W-1:0] r_r [3];
    logic signed [VEL_W-1:0] r_a [3], r_b [3], r_ld [3];
    logic signed [VEL_W:0]   r_d [3];
    logic signed [VEL_W+DIR_W:0] r_p [3];
    logic signed [VEL_W+DIR_W+2:0] r_k;
    logic signed [VEL_W+2:0] r_m [3];
    logic signed [VEL_W-1:0] r_na [3];
    logic r_ovalid;
    logic [1:0] r_status;
    logic signed [VEL_W-1:0] r_ox, r_oy, r_oz;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [VEL_W-1:0] w_wd [3], w_rd [3];

    // Store: one RAM per component.
    for (genvar c = 0; c < 3; c++) begin : g_ram
        rec_ram #(.WIDTH(VEL_W), .DEPTH(PARTICLE_COUNT)) u_ram (
            .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wd[c]),
            .i_raddr(w_raddr), .o_rdata(w_rd[c])
        );
    end

    assign o_q_ready = (r_state == S_IDLE);

    // Impulse for one component: k*r rounded half away, scaled by 2^-28.
    // k below 2^49 magnitude-wise after the positivity test; r at most 2^14.
    logic signed [VEL_W+DIR_W+DIR_W+3:0] w_prod [3];
    logic [VEL_W+DIR_W+DIR_W+3:0] w_mag [3];
    logic [VEL_W+DIR_W+DIR_W+3:0] w_rnd [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_prod[c] = r_k * r_r[c];
            w_mag[c]  = w_prod[c][VEL_W+DIR_W+DIR_W+3] ? -w_prod[c] : w_prod[c];
            w_rnd[c]  = (w_mag[c] + (VEL_W+DIR_W+DIR_W+4)'(1 << (SCALE_SHIFT-1)))
                        >> SCALE_SHIFT;
        end
    end

    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_waddr = r_ia;
        w_raddr = i_q_ia;
        for (int c = 0; c < 3; c++) w_wd[c] = r_ld[c];
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_op)
                        OP_LOAD:    n_state = S_WR_A;
                        OP_READ:    n_state = S_RD_A;
                        OP_COLLIDE: n_state = S_RD_A;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_RD_A: begin
                w_raddr = r_ib;
                n_state = (r_op == OP_READ) ? S_OUT : S_RD_B;
            end
            S_RD_B: n_state = S_DIFF;
            S_DIFF: n_state = S_DOT0;
            S_DOT0: n_state = S_DOT1;
            S_DOT1: n_state = S_SIGN;
            S_SIGN: n_state = (r_k > 0) ? S_MUL0 : S_OUT;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_WR_A;
            S_WR_A: begin
                w_we = 1'b1;
                if (r_op == OP_COLLIDE) begin
                    for (int c = 0; c < 3; c++) w_wd[c] = r_na[c];
                    n_state = S_WR_B;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WR_B: begin
                w_we = 1'b1;
                w_waddr = r_ib;
                for (int c = 0; c < 3; c++) w_wd[c] = sat32(35'(r_b[c]) + r_m[c]);
                n_state = S_OUT;
            end
            S_OUT: if (!r_ovalid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == S_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                r_op <= i_q_op;
                r_ia <= i_q_ia;
                r_ib <= i_q_ib;
                r_r[0] <= i_q_rx; r_r[1] <= i_q_ry; r_r[2] <= i_q_rz;
                r_ld[0] <= i_q_vx; r_ld[1] <= i_q_vy; r_ld[2] <= i_q_vz;
            end
            S_RD_A: for (int c = 0; c < 3; c++) r_a[c] <= w_rd[c];
            S_RD_B: begin
                for (int c = 0; c < 3; c++) r_b[c] <= w_rd[c];
                if (r_op == OP_READ)
                    for (int c = 0; c < 3; c++) r_a[c] <= r_a[c];
            end
            S_DIFF: for (int c = 0; c < 3; c++) r_d[c] <= 33'(r_a[c]) - 33'(r_b[c]);
            S_DOT0: for (int c = 0; c < 3; c++) r_p[c] <= r_d[c] * r_r[c];
            S_DOT1: r_k <= 51'(r_p[0]) + 51'(r_p[1]) + 51'(r_p[2]);
            S_MUL0: for (int c = 0; c < 3; c++)
                r_m[c] <= w_prod[c][VEL_W+DIR_W+DIR_W+3]
                    ? -35'(w_rnd[c]) : 35'(w_rnd[c]);
            S_MUL1: for (int c = 0; c < 3; c++) r_na[c] <= sat32(35'(r_a[c]) - r_m[c]);
            default: ;
        endcase
        if (r_state == S_OUT && (!r_ovalid || i_ready)) begin
            case (r_op)
                OP_LOAD:    r_status <= ST_LOADED;
                OP_READ:    r_status <= ST_READ;
                OP_COLLIDE: r_status <= (r_k > 0) ? ST_COLLIDED : ST_REJECTED;
                default:    r_status <= ST_REJECTED;
            endcase
            if (r_op == OP_READ) begin
                r_ox <= r_a[0]; r_oy <= r_a[1]; r_oz <= r_a[2];
            end else if (r_op == OP_COLLIDE && r_k > 0) begin
                r_ox <= r_na[0]; r_oy <= r_na[1]; r_oz <= r_na[2];
            end else begin
                r_ox <= '0; r_oy <= '0; r_oz <= '0;
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_status = r_status;
    assign o_out_x  = r_ox;
    assign o_out_y  = r_oy;
    assign o_out_z  = r_oz;

`include "random_elastic_collision_engine_defines.svh"
    `REC_ASSERT_NEXT(a_take_idle, i_clk, i_rst_n, o_q_ready && i_q_valid, r_state != S_IDLE, "queued transaction not taken")
    `REC_ASSERT_SAME(a_wr_state, i_clk, i_rst_n, w_we, r_state == S_WR_A || r_state == S_WR_B, "store written outside write-back")
    `REC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status), "result dropped")
endmodule

>>> test/tb_random_elastic_collision_engine.sv
module tb_random_elastic_collision_engine;
    import rec_pkg::*;

    localparam int unsigned NPART = PARTICLE_COUNT_DEF;
    localparam int unsigned RANDOM_ITEMS = 530;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned HOLD_START = 1500;
    localparam int unsigned HOLD_LENGTH = 300;
    localparam int unsigned CALM_FIRST = 2600;
    localparam int unsigned CALM_LAST = 3600;

    // One request as offered on the input channel. A flagged request is held
    // back until every awaited outcome has come out.
    typedef struct {
        logic [1:0]              req;
        logic [IDX_W-1:0]        ia;
        logic [IDX_W-1:0]        ib;
        logic signed [VEL_W-1:0] lx, ly, lz;
        logic signed [DIR_W-1:0] dx, dy, dz;
        bit                      drain_first;
    } t_request;

    typedef struct {
        logic [1:0]              status;
        logic signed [VEL_W-1:0] vx, vy, vz;
    } t_outcome;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [1:0]                i_req_type = REQ_LOAD;
    logic [IDX_W-1:0]          i_index_a = '0;
    logic [IDX_W-1:0]          i_index_b = '0;
    logic signed [VEL_W-1:0]   i_load_x = '0;
    logic signed [VEL_W-1:0]   i_load_y = '0;
    logic signed [VEL_W-1:0]   i_load_z = '0;
    logic signed [DIR_W-1:0]   i_dir_x = '0;
    logic signed [DIR_W-1:0]   i_dir_y = '0;
    logic signed [DIR_W-1:0]   i_dir_z = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [1:0]                o_status;
    logic signed [VEL_W-1:0]   o_out_x;
    logic signed [VEL_W-1:0]   o_out_y;
    logic signed [VEL_W-1:0]   o_out_z;

    t_request request_backlog[$];
    t_outcome awaited_outcomes[$];

    // Velocity table as the testbench believes it to be.
    logic signed [VEL_W-1:0] table_x[NPART];
    logic signed [VEL_W-1:0] table_y[NPART];
    logic signed [VEL_W-1:0] table_z[NPART];

    // Entries already loaded by the generated sequence, for picking safe
    // read and collide targets.
    bit                 gen_loaded[NPART];
    logic [IDX_W-1:0]   loaded_pool[$];

    int unsigned cycle_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned error_count = 0;
    int unsigned hold_left = 0;
    bit          req_taken = 1'b0;

    random_elastic_collision_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_index_a  (i_index_a),
        .i_index_b  (i_index_b),
        .i_load_x   (i_load_x),
        .i_load_y   (i_load_y),
        .i_load_z   (i_load_z),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_z    (o_out_z)
    );

    always #6 i_clk = ~i_clk;

    // Clamp one direction component to the unit range.
    function automatic longint limit_dir(input logic signed [DIR_W-1:0] d);
        longint v;
        v = d;
        if (v > 16384) begin
            v = 16384;
        end else if (v < -16384) begin
            v = -16384;
        end
        return v;
    endfunction

    // Scale k*r down by 2^28, rounding half away from zero.
    function automatic longint scaled_impulse(input longint k, input longint r);
        longint p;
        longint mag;
        p = k * r;
        mag = (p < 0) ? -p : p;
        mag = (mag + (64'sd1 <<< 27)) >>> 28;
        return (p < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [VEL_W-1:0] clip32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[VEL_W-1:0];
    endfunction

    // Apply one accepted transaction to the table and return the outcome
    // the block must produce for it.
    function automatic t_outcome apply_transaction(input t_request t);
        t_outcome o;
        longint rx, ry, rz, ax, ay, az, bx, by, bz, k, mx, my, mz;
        int unsigned a, b;
        a = t.ia % NPART;
        b = t.ib % NPART;
        o.status = ST_REJECTED;
        o.vx = '0;
        o.vy = '0;
        o.vz = '0;
        case (t.req)
            REQ_LOAD: begin
                table_x[a] = t.lx;
                table_y[a] = t.ly;
                table_z[a] = t.lz;
                o.status = ST_LOADED;
            end
            REQ_READ: begin
                o.status = ST_READ;
                o.vx = table_x[a];
                o.vy = table_y[a];
                o.vz = table_z[a];
            end
            REQ_COLLIDE: begin
                rx = limit_dir(t.dx);
                ry = limit_dir(t.dy);
                rz = limit_dir(t.dz);
                ax = table_x[a];
                ay = table_y[a];
                az = table_z[a];
                bx = table_x[b];
                by = table_y[b];
                bz = table_z[b];
                k = rx * (ax - bx) + ry * (ay - by) + rz * (az - bz);
                if (k > 0) begin
                    mx = scaled_impulse(k, rx);
                    my = scaled_impulse(k, ry);
                    mz = scaled_impulse(k, rz);
                    // A goes in first so a self-collision could never win.
                    table_x[a] = clip32(ax - mx);
                    table_y[a] = clip32(ay - my);
                    table_z[a] = clip32(az - mz);
                    table_x[b] = clip32(bx + mx);
                    table_y[b] = clip32(by + my);
                    table_z[b] = clip32(bz + mz);
                    o.status = ST_COLLIDED;
                    o.vx = clip32(ax - mx);
                    o.vy = clip32(ay - my);
                    o.vz = clip32(az - mz);
                end
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [VEL_W-1:0] got,
                                   input logic [VEL_W-1:0] want);
        $display("mismatch %s: got %h, want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Queue a request, keeping track of which entries have been loaded.
    task automatic queue_request(input logic [1:0] req, input logic [IDX_W-1:0] ia,
                                 input logic [IDX_W-1:0] ib,
                                 input logic signed [VEL_W-1:0] lx,
                                 input logic signed [VEL_W-1:0] ly,
                                 input logic signed [VEL_W-1:0] lz,
                                 input logic signed [DIR_W-1:0] dx,
                                 input logic signed [DIR_W-1:0] dy,
                                 input logic signed [DIR_W-1:0] dz,
                                 input bit drain_first);
        t_request t;
        t.req = req;
        t.ia = ia;
        t.ib = ib;
        t.lx = lx;
        t.ly = ly;
        t.lz = lz;
        t.dx = dx;
        t.dy = dy;
        t.dz = dz;
        t.drain_first = drain_first;
        if (req == REQ_LOAD && !gen_loaded[ia]) begin
            gen_loaded[ia] = 1'b1;
            loaded_pool.push_back(ia);
        end
        request_backlog.push_back(t);
    endtask

    function automatic logic [IDX_W-1:0] pick_loaded();
        return loaded_pool[$urandom_range(loaded_pool.size() - 1)];
    endfunction

    // Mostly moderate velocities so collisions stay meaningful, with a share of
    // full-width words to reach every bit and the saturation rails.
    function automatic logic signed [VEL_W-1:0] rand_velocity();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 3) begin
            return $urandom;
        end else if (sel == 3) begin
            return ($urandom_range(1)) ? 32'sh7FFFFFF0 + $urandom_range(15)
                                       : 32'sh80000000 + $urandom_range(15);
        end
        return $signed($urandom_range(2000000)) - 32'sd1000000;
    endfunction

    // Mostly in-range directions; some raw words to exercise the clamp.
    function automatic logic signed [DIR_W-1:0] rand_direction();
        if ($urandom_range(9) == 0) begin
            return DIR_W'($urandom);
        end
        return DIR_W'($signed($urandom_range(32768)) - 32'sd16384);
    endfunction

    task automatic queue_random(input bit drain_first);
        int unsigned sel;
        logic [1:0] req;
        logic [IDX_W-1:0] ia, ib;
        sel = $urandom_range(99);
        ia = IDX_W'($urandom);
        ib = IDX_W'($urandom);
        if (sel < 25 || loaded_pool.size() < 2) begin
            req = REQ_LOAD;
            // Reuse loaded entries often so collisions see fresh data.
            if ($urandom_range(1)) begin
                ia = (loaded_pool.size() > 0) ? pick_loaded() : ia;
            end
        end else if (sel < 45) begin
            req = REQ_READ;
            ia = pick_loaded();
        end else if (sel < 95) begin
            req = REQ_COLLIDE;
            ia = pick_loaded();
            ib = ($urandom_range(19) == 0) ? ia : pick_loaded();
        end else begin
            req = 2'd3;
        end
        queue_request(req, ia, ib, rand_velocity(), rand_velocity(), rand_velocity(),
                      rand_direction(), rand_direction(), rand_direction(), drain_first);
    endtask

    // Monitor: flag input transactions, predict, and check outcomes.
    always @(posedge i_clk) begin
        t_outcome got, want;
        t_request t;
        cycle_count <= cycle_count + 1;
        req_taken = i_rst_n && i_valid && o_ready;
        if (req_taken) begin
            t.req = i_req_type;
            t.ia = i_index_a;
            t.ib = i_index_b;
            t.lx = i_load_x;
            t.ly = i_load_y;
            t.lz = i_load_z;
            t.dx = i_dir_x;
            t.dy = i_dir_y;
            t.dz = i_dir_z;
            t.drain_first = 1'b0;
            awaited_outcomes.push_back(apply_transaction(t));
        end
        if (i_rst_n && o_valid && i_ready) begin
            got.status = o_status;
            got.vx = o_out_x;
            got.vy = o_out_y;
            got.vz = o_out_z;
            if (awaited_outcomes.size() == 0) begin
                report_mismatch("unexpected result", {30'd0, got.status}, '0);
            end else begin
                want = awaited_outcomes.pop_front();
                if (got.status !== want.status) begin
                    report_mismatch("status", {30'd0, got.status}, {30'd0, want.status});
                end
                if (got.vx !== want.vx) begin
                    report_mismatch("out_x", got.vx, want.vx);
                end
                if (got.vy !== want.vy) begin
                    report_mismatch("out_y", got.vy, want.vy);
                end
                if (got.vz !== want.vz) begin
                    report_mismatch("out_z", got.vz, want.vz);
                end
            end
        end
        // Watchdog: count cycles with no transaction on either channel.
        if (!i_rst_n || req_taken || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Driver: hold the payload until taken, then fetch the next request.
    always @(negedge i_clk) begin
        t_request t;
        bit idle;
        idle = !(cycle_count >= CALM_FIRST && cycle_count <= CALM_LAST)
               && ($urandom_range(99) < 18);
        if (!i_rst_n || (i_valid && !req_taken)) begin
            // hold
        end else if (request_backlog.size() > 0 && !idle
                     && !(request_backlog[0].drain_first && awaited_outcomes.size() != 0)) begin
            t = request_backlog.pop_front();
            i_req_type <= t.req;
            i_index_a <= t.ia;
            i_index_b <= t.ib;
            i_load_x <= t.lx;
            i_load_y <= t.ly;
            i_load_z <= t.lz;
            i_dir_x <= t.dx;
            i_dir_y <= t.dy;
            i_dir_z <= t.dz;
            i_valid <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, one long hold-off to fill the block,
    // and a calm window with no stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (cycle_count == HOLD_START) begin
            hold_left <= HOLD_LENGTH;
            i_ready <= 1'b0;
        end else if (cycle_count >= CALM_FIRST && cycle_count <= CALM_LAST) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 18);
        end
    end

    initial begin
        int unsigned n;
        // Directed: rails, index extremes, saturation, clamp, self-collision,
        // non-positive k, unused request code.
        queue_request(REQ_LOAD, 12'd0, 12'hFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_LOAD, 12'hFFF, 12'd0, 32'sh80000000, 32'sh80000000, 32'sd4096,
                      16'sh7FFF, 16'sh8000, 16'sd1, 1'b0);
        queue_request(REQ_READ, 12'd0, 12'd5, 32'sd0, 32'sd0, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_READ, 12'hFFF, 12'd0, 32'sd0, 32'sd0, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_COLLIDE, 12'd0, 12'hFFF, 32'sd0, 32'sd0, 32'sd0,
                      16'sd16384, 16'sd16384, 16'sd0, 1'b0);
        queue_request(REQ_READ, 12'd0, 12'd0, 32'sd0, 32'sd0, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_READ, 12'hFFF, 12'd0, 32'sd0, 32'sd0, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_LOAD, 12'd1, 12'd0, 32'sd40960, -32'sd8192, 32'sd12288,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_LOAD, 12'd2, 12'd0, -32'sd4096, 32'sd4096, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_COLLIDE, 12'd1, 12'd1, 32'sd0, 32'sd0, 32'sd0,
                      16'sd16384, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_COLLIDE, 12'd1, 12'd2, 32'sd0, 32'sd0, 32'sd0,
                      -16'sd16384, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_COLLIDE, 12'd1, 12'd2, 32'sd0, 32'sd0, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_COLLIDE, 12'd1, 12'd2, 32'sd0, 32'sd0, 32'sd0,
                      16'sh7FFF, 16'sh8000, 16'sd100, 1'b0);
        queue_request(REQ_COLLIDE, 12'd2, 12'd1, 32'sd0, 32'sd0, 32'sd0,
                      16'sd11585, 16'sd0, -16'sd11585, 1'b0);
        queue_request(REQ_READ, 12'd1, 12'd0, 32'sd0, 32'sd0, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_request(REQ_READ, 12'd2, 12'd0, 32'sd0, 32'sd0, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_request(2'd3, 12'hFFF, 12'hFFF, 32'sh7FFFFFFF, 32'sd0, 32'sd0,
                      16'sd1, 16'sd1, 16'sd1, 1'b0);
        queue_request(REQ_COLLIDE, 12'hFFF, 12'd0, 32'sd0, 32'sd0, 32'sd0,
                      16'sd0, -16'sd16384, 16'sd16384, 1'b0);
        queue_request(REQ_READ, 12'hFFF, 12'd0, 32'sd0, 32'sd0, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0, 1'b0);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // One pause mid-run until the block has emptied.
            queue_random(n == RANDOM_ITEMS / 2);
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (request_backlog.size() != 0 || i_valid || awaited_outcomes.size() != 0);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
